// File: hw/rtl/bta_pkg.sv
package bta_pkg;

  // tree geometry
  localparam int unsigned MaxTreeLevels = 10;
  localparam int unsigned NodeCap       = (1 << MaxTreeLevels) - 1;
  localparam int unsigned NodeW         = MaxTreeLevels;
  localparam int unsigned SubW          = NodeW + 1;
  localparam int unsigned LvlW          = 4;

  // field widths
  localparam int unsigned SizeW   = 25;
  localparam int unsigned OffW    = 24;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CfgW-1:0] MemLog2Max   = 5'd24;
  localparam logic [CfgW-1:0] MemLog2Rst   = 5'd20;
  localparam logic [CfgW-1:0] MinBlkLog2Rst = 5'd11;
  localparam logic [OffW-1:0] HdrBytes     = 24'd4;

  // register indexes (paddr bit 2)
  localparam logic REG_MEM_LOG2 = 1'b0;
  localparam logic REG_MIN_BLK  = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [StatusW-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [StatusW-1:0] ST_RANGE     = 3'd3;
  localparam logic [StatusW-1:0] ST_MISALIGN  = 3'd4;
  localparam logic [StatusW-1:0] ST_DBL_FREE  = 3'd5;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_LVL_STEP,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_FCHK,
    OP_FOUND,
    OP_SUB_STEP,
    OP_ANC_STEP,
    OP_MRG_RD,
    OP_MRG_STEP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               res_en;
    logic [StatusW-1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic bad_size;
    logic lvl_more;
    logic lvl_neg;
    logic scan_free;
    logic scan_last;
    logic range_err;
    logic index_err;
    logic busy_bit;
    logic sub_last;
    logic at_root;
  } stat_t;

endpackage

// File: hw/rtl/bta_ctrl.sv
module bta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bta_pkg::stat_t  stat_i,
  output bta_pkg::cmd_t   cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISP     = 4'd2;
  localparam logic [3:0] S_LVL      = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_FBUSY    = 4'd6;
  localparam logic [3:0] S_SUB      = 4'd7;
  localparam logic [3:0] S_ANC      = 4'd8;
  localparam logic [3:0] S_MRG_RD   = 4'd9;
  localparam logic [3:0] S_MRG_CHK  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       done_q, done_d;

  // next state and datapath command
  always_comb begin
    state_d        = state_q;
    cmd_o.op       = bta_pkg::OP_NONE;
    cmd_o.res_en   = 1'b0;
    cmd_o.res_code = bta_pkg::ST_OK;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = bta_pkg::OP_CLR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = bta_pkg::OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat_i.is_free) begin
          if (stat_i.bad_size) begin
            cmd_o.res_en   = 1'b1;
            cmd_o.res_code = bta_pkg::ST_BAD_SIZE;
            state_d        = S_IDLE;
          end else begin
            state_d = S_LVL;
          end
        end else begin
          cmd_o.op = bta_pkg::OP_FCHK;
          if (stat_i.range_err) begin
            cmd_o.res_en   = 1'b1;
            cmd_o.res_code = bta_pkg::ST_RANGE;
            state_d        = S_IDLE;
          end else if (stat_i.index_err) begin
            cmd_o.res_en   = 1'b1;
            cmd_o.res_code = bta_pkg::ST_MISALIGN;
            state_d        = S_IDLE;
          end else begin
            state_d = S_FBUSY;
          end
        end
      end
      S_LVL: begin
        if (stat_i.lvl_more) begin
          cmd_o.op = bta_pkg::OP_LVL_STEP;
        end else if (stat_i.lvl_neg) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_code = bta_pkg::ST_BAD_SIZE;
          state_d        = S_IDLE;
        end else begin
          cmd_o.op = bta_pkg::OP_SCAN_INIT;
          state_d  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.op = bta_pkg::OP_SCAN_RD;
        state_d  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat_i.scan_free) begin
          cmd_o.op = bta_pkg::OP_FOUND;
          state_d  = S_SUB;
        end else if (stat_i.scan_last) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_code = bta_pkg::ST_NO_SPACE;
          state_d        = S_IDLE;
        end else begin
          cmd_o.op = bta_pkg::OP_SCAN_NEXT;
          state_d  = S_SCAN_RD;
        end
      end
      S_FBUSY: begin
        if (!stat_i.busy_bit) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_code = bta_pkg::ST_DBL_FREE;
          state_d        = S_IDLE;
        end else begin
          cmd_o.op = bta_pkg::OP_FOUND;
          state_d  = S_SUB;
        end
      end
      S_SUB: begin
        cmd_o.op = bta_pkg::OP_SUB_STEP;
        if (stat_i.sub_last) state_d = stat_i.is_free ? S_MRG_RD : S_ANC;
      end
      S_ANC: begin
        if (stat_i.at_root) begin
          cmd_o.res_en = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = bta_pkg::OP_ANC_STEP;
        end
      end
      S_MRG_RD: begin
        if (stat_i.at_root) begin
          cmd_o.res_en = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = bta_pkg::OP_MRG_RD;
          state_d  = S_MRG_CHK;
        end
      end
      S_MRG_CHK: begin
        if (stat_i.busy_bit) begin
          cmd_o.res_en = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = bta_pkg::OP_MRG_STEP;
          state_d  = S_MRG_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_d = cmd_o.res_en;

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // accepted transaction keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not make block busy");

  // result strobes never touch: every result returns the controller to idle
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("back to back result strobes");

  // a result only follows work
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != S_IDLE && state_q != S_CLR))
    else $error("result strobe without a transaction");

endmodule

// File: hw/rtl/bta_datapath.sv
module bta_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bta_pkg::cmd_t                    cmd_i,
  output bta_pkg::stat_t                   stat_o,
  input  logic [bta_pkg::CfgW-1:0]         mem_log2_i,
  input  logic [bta_pkg::CfgW-1:0]         min_block_log2_i,
  input  logic                             func_i,
  input  logic [bta_pkg::SizeW-1:0]        req_size_i,
  input  logic [bta_pkg::OffW-1:0]         user_offset_i,
  input  logic [bta_pkg::NodeW-1:0]        header_index_i,
  output logic [bta_pkg::StatusW-1:0]      status_o,
  output logic [bta_pkg::OffW-1:0]         block_offset_o,
  output logic [bta_pkg::NodeW-1:0]        node_index_o
);

  localparam int unsigned NW = bta_pkg::NodeW;
  localparam int unsigned SW = bta_pkg::SubW;

  // latched transaction
  logic                        func_q;
  logic [bta_pkg::SizeW-1:0]   size_q;
  logic [bta_pkg::OffW-1:0]    uoff_q;
  logic [NW-1:0]               hidx_q;

  // working registers
  logic [bta_pkg::CfgW-1:0]    clr_unused;
  logic [NW-1:0]               clr_q;
  logic signed [4:0]           level_q;
  logic [bta_pkg::CfgW-1:0]    blk_log_q;
  logic [NW-1:0]               i_q;
  logic [SW-1:0]               cur_q, lo_q, hi_q;
  logic [NW-1:0]               p_q;
  logic                        rdata_q;

  logic [bta_pkg::StatusW-1:0] status_q;
  logic [bta_pkg::OffW-1:0]    boff_q;
  logic [NW-1:0]               node_q;

  // memory of busy bits
  logic                        busy_mem [bta_pkg::NodeCap];
  logic                        we;
  logic [NW-1:0]               waddr, raddr;
  logic                        wdata;

  // geometry from configuration
  logic [bta_pkg::CfgW-1:0]    mlog;
  logic [bta_pkg::CfgW-1:0]    lv_diff;
  logic [bta_pkg::LvlW-1:0]    levels;
  logic [NW-1:0]               nodes;
  logic [bta_pkg::SizeW-1:0]   msize;

  always_comb begin
    mlog    = (mem_log2_i > bta_pkg::MemLog2Max) ? bta_pkg::MemLog2Max : mem_log2_i;
    lv_diff = mlog - min_block_log2_i + 5'd1;
    if (min_block_log2_i > mlog) begin
      levels = 4'd1;
    end else if (lv_diff > 5'(bta_pkg::MaxTreeLevels)) begin
      levels = 4'(bta_pkg::MaxTreeLevels);
    end else begin
      levels = lv_diff[3:0];
    end
    nodes = NW'((SW'(1) << levels) - SW'(1));
    msize = bta_pkg::SizeW'(1) << mlog;
  end

  assign clr_unused = '0;

  // allocation size and level search
  logic [25:0]   need, blk;
  logic [NW-1:0] first, last;
  logic [3:0]    lvl4;

  always_comb begin
    need  = {1'b0, size_q} + 26'd4;
    blk   = 26'd1 << blk_log_q;
    lvl4  = level_q[3:0];
    first = NW'((SW'(1) << lvl4) - SW'(1));
    last  = NW'((SW'(1) << (lvl4 + 4'd1)) - SW'(2));
  end

  // free checks: level of header index and its block start
  logic [SW-1:0]            hv;
  logic [3:0]               hl;
  logic [NW-1:0]            hfirst;
  logic [bta_pkg::SizeW-1:0] fstart;
  logic                     misalign;

  always_comb begin
    hv = {1'b0, hidx_q} + SW'(1);
    hl = '0;
    for (int b = 1; b < SW; b++) begin
      if (hv[b]) hl = 4'(b);
    end
    hfirst   = NW'((SW'(1) << hl) - SW'(1));
    fstart   = bta_pkg::SizeW'(hidx_q - hfirst) << (mlog - {1'b0, hl});
    misalign = ({2'b0, uoff_q} != ({1'b0, fstart} + 26'd4));
  end

  // tree walk helpers
  logic [NW-1:0] parent, buddy, base;
  logic [SW-1:0] lo_next, hi_next;

  always_comb begin
    parent  = (p_q - NW'(1)) >> 1;
    buddy   = p_q[0] ? (p_q + NW'(1)) : (p_q - NW'(1));
    base    = func_q ? hidx_q : i_q;
    lo_next = {lo_q[NW-1:0], 1'b1};
    hi_next = {hi_q[NW-1:0], 1'b0} + SW'(2);
  end

  // status toward the controller
  always_comb begin
    stat_o.clr_last  = (clr_q == NW'(bta_pkg::NodeCap - 1));
    stat_o.is_free   = func_q;
    stat_o.bad_size  = (size_q == '0) || (size_q > msize);
    stat_o.lvl_more  = (blk < need) && !level_q[4];
    stat_o.lvl_neg   = level_q[4];
    stat_o.scan_free = !rdata_q;
    stat_o.scan_last = (i_q == last);
    stat_o.range_err = ({1'b0, uoff_q} >= msize);
    stat_o.index_err = (hidx_q >= nodes) || misalign;
    stat_o.busy_bit  = rdata_q;
    stat_o.sub_last  = (cur_q == hi_q) && (lo_next >= {1'b0, nodes});
    stat_o.at_root   = (p_q == '0);
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = 1'b0;
    raddr = '0;
    case (cmd_i.op)
      bta_pkg::OP_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      bta_pkg::OP_SUB_STEP: begin
        we    = 1'b1;
        waddr = cur_q[NW-1:0];
        wdata = !func_q;
      end
      bta_pkg::OP_ANC_STEP: begin
        we    = 1'b1;
        waddr = parent;
        wdata = 1'b1;
      end
      bta_pkg::OP_MRG_STEP: begin
        we    = 1'b1;
        waddr = parent;
      end
      bta_pkg::OP_SCAN_RD: raddr = i_q;
      bta_pkg::OP_FCHK:    raddr = hidx_q;
      bta_pkg::OP_MRG_RD:  raddr = buddy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) busy_mem[waddr] <= wdata;
    rdata_q <= busy_mem[raddr];
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.op == bta_pkg::OP_CLR) begin
      clr_q <= clr_q + NW'(1) + NW'(clr_unused);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bta_pkg::OP_LOAD: begin
        func_q    <= func_i;
        size_q    <= req_size_i;
        uoff_q    <= user_offset_i;
        hidx_q    <= header_index_i;
        level_q   <= 5'({1'b0, levels} - 5'd1);
        blk_log_q <= mlog - ({1'b0, levels} - 5'd1);
        boff_q    <= '0;
        node_q    <= '0;
      end
      bta_pkg::OP_LVL_STEP: begin
        level_q   <= level_q - 5'sd1;
        blk_log_q <= blk_log_q + 5'd1;
      end
      bta_pkg::OP_SCAN_INIT: i_q <= first;
      bta_pkg::OP_SCAN_NEXT: i_q <= i_q + NW'(1);
      bta_pkg::OP_FOUND: begin
        cur_q <= {1'b0, base};
        lo_q  <= {1'b0, base};
        hi_q  <= {1'b0, base};
        p_q   <= base;
        if (!func_q) begin
          node_q <= i_q;
          boff_q <= (bta_pkg::OffW'(i_q - first) << blk_log_q) + bta_pkg::HdrBytes;
        end
      end
      bta_pkg::OP_SUB_STEP: begin
        if (cur_q == hi_q) begin
          lo_q  <= lo_next;
          hi_q  <= hi_next;
          cur_q <= lo_next;
        end else begin
          cur_q <= cur_q + SW'(1);
        end
      end
      bta_pkg::OP_ANC_STEP, bta_pkg::OP_MRG_STEP: p_q <= parent;
      default: ;
    endcase
    if (cmd_i.res_en) status_q <= cmd_i.res_code;
  end

  assign status_o       = status_q;
  assign block_offset_o = boff_q;
  assign node_index_o   = node_q;

  // subtree writes stay inside the current tree
  a_sub_in_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == bta_pkg::OP_SUB_STEP) |-> (cur_q < {1'b0, nodes}))
    else $error("subtree write outside the tree");

  // ancestor and merge walks never step above the root
  a_walk_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == bta_pkg::OP_ANC_STEP || cmd_i.op == bta_pkg::OP_MRG_STEP)
      |-> (p_q != '0))
    else $error("tree walk past the root");

  // clearing pass never runs beyond the last node
  a_clr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == bta_pkg::OP_CLR) |-> (clr_q < NW'(bta_pkg::NodeCap)))
    else $error("clearing pass beyond the memory");

endmodule

// File: hw/rtl/buddy_tree_allocator_unit.sv
// an allocation runs level steps, a node scan, the subtree and the ancestors;
// a free runs the subtree and the merge steps; some requests are rejected at dispatch
// one transaction at a time: start is taken only while busy is low
// results show for one cycle on done_o; the receiver cannot stall
// after reset a clearing pass runs with busy high
module buddy_tree_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  output logic                                done_o,
  input  logic                                func_i,
  input  logic [bta_pkg::SizeW-1:0]           req_size_i,
  input  logic [bta_pkg::OffW-1:0]            user_offset_i,
  input  logic [bta_pkg::NodeW-1:0]           header_index_i,
  output logic [bta_pkg::StatusW-1:0]         status_o,
  output logic [bta_pkg::OffW-1:0]            block_offset_o,
  output logic [bta_pkg::NodeW-1:0]           node_index_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bta_pkg::ApbAddrW-1:0]        paddr,
  input  logic [bta_pkg::ApbDataW-1:0]        pwdata,
  output logic [bta_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready
);

  logic [bta_pkg::CfgW-1:0] mem_log2_q, min_blk_q;
  bta_pkg::cmd_t            cmd;
  bta_pkg::stat_t           stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_log2_q <= bta_pkg::MemLog2Rst;
      min_blk_q  <= bta_pkg::MinBlkLog2Rst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == bta_pkg::REG_MEM_LOG2) begin
        mem_log2_q <= pwdata[bta_pkg::CfgW-1:0];
      end else begin
        min_blk_q <= pwdata[bta_pkg::CfgW-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bta_pkg::REG_MIN_BLK)
                ? {{(bta_pkg::ApbDataW-bta_pkg::CfgW){1'b0}}, min_blk_q}
                : {{(bta_pkg::ApbDataW-bta_pkg::CfgW){1'b0}}, mem_log2_q};

  bta_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bta_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .mem_log2_i       (mem_log2_q),
    .min_block_log2_i (min_blk_q),
    .func_i           (func_i),
    .req_size_i       (req_size_i),
    .user_offset_i    (user_offset_i),
    .header_index_i   (header_index_i),
    .status_o         (status_o),
    .block_offset_o   (block_offset_o),
    .node_index_o     (node_index_o)
  );

endmodule
